// File: hdl/cpe_pkg.sv
// shared types and constants of the chebyshev polynomial evaluator
`timescale 1ns / 1ps
`default_nettype none
package cpe_pkg;

	// field widths
	localparam int X_W     = 16;
	localparam int VAL_W   = 32;
	localparam int ORDER_W = 7;
	localparam int KIND_W  = 1;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = ORDER_W;
	localparam logic [CFG_IDX_W-1:0] REG_POLY_KIND  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_POLY_ORDER = 1'b1;

	// register reset values
	localparam logic [KIND_W-1:0]  KIND_RST  = 1'b0;
	localparam logic [ORDER_W-1:0] ORDER_RST = 7'd1;

	// polynomial kinds
	localparam logic [KIND_W-1:0] KIND_FIRST  = 1'b0;
	localparam logic [KIND_W-1:0] KIND_SECOND = 1'b1;

	// parameter defaults
	localparam int MAX_ORDER_DEF = 64;
	localparam int FRAC_BITS_DEF = 14;

	// datapath widths: product of x and prev, then a guard for doubling and rounding
	localparam int PROD_W = X_W + VAL_W;
	localparam int SUM_W  = PROD_W + 2;

	// saturation limits
	localparam logic [VAL_W-1:0] VAL_MAX = 32'h7fff_ffff;
	localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;

	// commands from controller to datapath
	typedef struct packed {
		logic load;       // take a new sample and seed the recurrence
		logic zero_seed;  // order zero: result is the constant one
		logic mul;        // register x * prev
		logic step;       // finish one recurrence step
		logic out_load;   // move the result into the output register
	} cmd_t;

endpackage
`default_nettype wire

// File: hdl/cpe_in_if.sv
// input channel: sample and last-element mark
`timescale 1ns / 1ps
`default_nettype none
interface cpe_in_if;
	logic                          valid;
	logic                          ready;
	logic signed [cpe_pkg::X_W-1:0] sample_x;
	logic                          is_last;

	modport source (output valid, output sample_x, output is_last, input ready);
	modport sink   (input valid, input sample_x, input is_last, output ready);
endinterface
`default_nettype wire

// File: hdl/cpe_out_if.sv
// output channel: polynomial value, overflow flag and last-element mark
`timescale 1ns / 1ps
`default_nettype none
interface cpe_out_if;
	logic                            valid;
	logic                            ready;
	logic signed [cpe_pkg::VAL_W-1:0] poly_value;
	logic                            overflowed;
	logic                            last_out;

	modport source (output valid, output poly_value, output overflowed, output last_out,
		input ready);
	modport sink   (input valid, input poly_value, input overflowed, input last_out,
		output ready);
endinterface
`default_nettype wire

// File: hdl/cpe_cfg_if.sv
// configuration write channel
`timescale 1ns / 1ps
`default_nettype none
interface cpe_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [cpe_pkg::CFG_IDX_W-1:0]   index;
	logic [cpe_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/cpe_ctrl.sv
// controller state machine: sequences the recurrence steps for one sample
`timescale 1ns / 1ps
`default_nettype none
module cpe_ctrl #(
	parameter int MAX_ORDER = cpe_pkg::MAX_ORDER_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output      logic                        in_ready,
	input  wire logic [cpe_pkg::ORDER_W-1:0] order,
	input  wire logic                        out_free,
	output      cpe_pkg::cmd_t               cmd
);

	localparam int CNT_W = $clog2(MAX_ORDER + 1);
	localparam int OEX_W = (CNT_W > cpe_pkg::ORDER_W) ? CNT_W : cpe_pkg::ORDER_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_ACC  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [1:0]       state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] ord_q;
	logic [OEX_W-1:0] ord_ext;
	logic [CNT_W-1:0] ord_clamp;

	// clamp the order to the largest supported one
	assign ord_ext   = OEX_W'(order);
	assign ord_clamp = (ord_ext > OEX_W'(MAX_ORDER)) ? CNT_W'(MAX_ORDER) : CNT_W'(ord_ext);

	assign in_ready = (state_q == ST_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load      = 1'b1;
					cmd.zero_seed = (ord_clamp == '0);
					state_d       = (ord_clamp < CNT_W'(2)) ? ST_FIN : ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.step = 1'b1;
				state_d  = (cnt_q == ord_q) ? ST_FIN : ST_MUL;
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state, step counter and captured order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			ord_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				cnt_q <= CNT_W'(2);
				ord_q <= ord_clamp;
			end else if (cmd.step) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	// a transfer always starts either the step loop or the final hand-over
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_MUL || state_q == ST_FIN))
		else $error("transfer did not start processing");

	// the step counter stays within the captured order
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACC) |-> (cnt_q >= CNT_W'(2) && cnt_q <= ord_q))
		else $error("step counter out of range");

endmodule
`default_nettype wire

// File: hdl/cpe_dpath.sv
// datapath: shared multiply, round, subtract and saturate, plus output register
`timescale 1ns / 1ps
`default_nettype none
module cpe_dpath #(
	parameter int FRAC_BITS = cpe_pkg::FRAC_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire cpe_pkg::cmd_t                    cmd,
	input  wire logic [cpe_pkg::KIND_W-1:0]       kind,
	input  wire logic signed [cpe_pkg::X_W-1:0]   sample_x,
	input  wire logic                             is_last,
	output      logic                             out_free,
	output      logic                             out_valid,
	input  wire logic                             out_ready,
	output      logic signed [cpe_pkg::VAL_W-1:0] poly_value,
	output      logic                             overflowed,
	output      logic                             last_out
);

	localparam int VW = cpe_pkg::VAL_W;
	localparam int PW = cpe_pkg::PROD_W;
	localparam int SW = cpe_pkg::SUM_W;
	localparam logic signed [VW-1:0] ONE  = VW'(1) <<< FRAC_BITS;
	localparam logic signed [SW-1:0] HALF = SW'(1) <<< (FRAC_BITS - 1);

	logic signed [cpe_pkg::X_W-1:0] x_q;
	logic signed [VW-1:0]           prev_q, pp_q;
	logic signed [PW-1:0]           prod_q;
	logic                           ovf_q, last_q;
	logic                           out_valid_q;
	logic signed [VW-1:0]           val_out_q;
	logic                           ovf_out_q, last_out_q;

	logic signed [VW-1:0] seed;
	logic signed [SW-1:0] dbl, rnd, shr, diff;
	logic [SW-VW:0]       hi_bits;
	logic                 fits;
	logic signed [VW-1:0] sat_val;

	// second seed: x for the first kind, 2x for the second, the constant one for order zero
	always_comb begin
		if (cmd.zero_seed) begin
			seed = ONE;
		end else if (kind == cpe_pkg::KIND_SECOND) begin
			seed = VW'(sample_x) <<< 1;
		end else begin
			seed = VW'(sample_x);
		end
	end

	// 2 * product, round half up, drop fraction bits, subtract prevprev
	assign dbl  = SW'(prod_q) <<< 1;
	assign rnd  = dbl + HALF;
	assign shr  = rnd >>> FRAC_BITS;
	assign diff = shr - SW'(pp_q);

	// saturate to 32 bits
	assign hi_bits = diff[SW-1:VW-1];
	assign fits    = (&hi_bits) | ~(|hi_bits);
	assign sat_val = fits ? diff[VW-1:0] :
		(diff[SW-1] ? cpe_pkg::VAL_MIN : cpe_pkg::VAL_MAX);

	// recurrence registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q    <= sample_x;
			last_q <= is_last;
			prev_q <= seed;
			pp_q   <= ONE;
			ovf_q  <= 1'b0;
		end else begin
			if (cmd.mul) begin
				prod_q <= PW'(x_q) * PW'(prev_q);
			end
			if (cmd.step) begin
				prev_q <= sat_val;
				pp_q   <= prev_q;
				ovf_q  <= ovf_q | ~fits;
			end
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			val_out_q  <= prev_q;
			ovf_out_q  <= ovf_q;
			last_out_q <= last_q;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_free   = !out_valid_q || out_ready;
	assign out_valid  = out_valid_q;
	assign poly_value = val_out_q;
	assign overflowed = ovf_out_q;
	assign last_out   = last_out_q;

	// a new result never overwrites one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("output register overwritten");

	// a saturating step leaves an extreme value and sets the flag
	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && !cmd.load && !fits) |=>
			((prev_q == cpe_pkg::VAL_MAX || prev_q == cpe_pkg::VAL_MIN) && ovf_q))
		else $error("saturation not applied");

	// the overflow flag starts clear for each sample
	a_ovf_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !ovf_q)
		else $error("overflow flag not cleared on load");

endmodule
`default_nettype wire

// File: hdl/chebyshev_poly_eval.sv
// top level: chebyshev polynomial evaluator with configuration registers
// an input transfer loads the sample; orders 0 and 1 go straight to the hand-over to the output register
// order n >= 2 runs one recurrence step for each order from 2 to n; a new sample is taken only when idle
// each recurrence step runs through the MUL and ACC states in the one shared multiplier and subtract-saturate unit
// a result waiting in the output register does not block the next input transfer
// reset: asynchronous, clears control and sets kind to first and order to 1
`timescale 1ns / 1ps
`default_nettype none
module chebyshev_poly_eval #(
	parameter int MAX_ORDER = cpe_pkg::MAX_ORDER_DEF,
	parameter int FRAC_BITS = cpe_pkg::FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	cpe_in_if.sink   operand,
	cpe_out_if.source result,
	cpe_cfg_if.sink  cfg
);

	logic [cpe_pkg::KIND_W-1:0]  kind_q;
	logic [cpe_pkg::ORDER_W-1:0] order_q;
	logic                        out_free;
	cpe_pkg::cmd_t               cmd;

	// configuration registers, always ready
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q  <= cpe_pkg::KIND_RST;
			order_q <= cpe_pkg::ORDER_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				cpe_pkg::REG_POLY_KIND:  kind_q  <= cfg.data[cpe_pkg::KIND_W-1:0];
				cpe_pkg::REG_POLY_ORDER: order_q <= cfg.data[cpe_pkg::ORDER_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// controller
	cpe_ctrl #(
		.MAX_ORDER(MAX_ORDER)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (operand.valid),
		.in_ready (operand.ready),
		.order    (order_q),
		.out_free (out_free),
		.cmd      (cmd)
	);

	// datapath
	cpe_dpath #(
		.FRAC_BITS(FRAC_BITS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.kind       (kind_q),
		.sample_x   (operand.sample_x),
		.is_last    (operand.is_last),
		.out_free   (out_free),
		.out_valid  (result.valid),
		.out_ready  (result.ready),
		.poly_value (result.poly_value),
		.overflowed (result.overflowed),
		.last_out   (result.last_out)
	);

endmodule
`default_nettype wire
